>>> rtl/vtre_pkg.sv
package vtre_pkg;

  localparam int unsigned RateW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned AccW     = 32;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned AlongW   = 33;
  localparam int unsigned DivW     = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned TrimSamplesDef = 64;

  localparam logic [RateW-1:0] RateFloorRst  = 16'd500;
  localparam logic [RateW-1:0] StaleLimitRst = 16'd100;

  localparam logic [CfgIdxW-1:0] CfgRateFloor  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgStaleLimit = 1'd1;

  // serial unit step counts
  localparam int unsigned DigitW    = 4;
  localparam int unsigned MulSteps  = RateW / DigitW;
  localparam int unsigned SqrtSteps = ProdW / 2;
  localparam int unsigned DivSteps  = ProdW;
  localparam int unsigned MulCntW   = $clog2(MulSteps);
  localparam int unsigned SqrtCntW  = $clog2(SqrtSteps);
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  // product terms: three squares, then the three projection terms
  localparam int unsigned TermW = 3;
  localparam logic [TermW-1:0] TermRightSq = 3'd0;
  localparam logic [TermW-1:0] TermUpSq    = 3'd1;
  localparam logic [TermW-1:0] TermAftSq   = 3'd2;
  localparam logic [TermW-1:0] TermRollAft = 3'd3;
  localparam logic [TermW-1:0] TermPitchRt = 3'd4;
  localparam logic [TermW-1:0] TermYawUp   = 3'd5;

  typedef struct packed {
    logic [RateW-1:0] a;
    logic [RateW-1:0] b;
    logic             neg;
  } term_ops_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_TRIM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_e;

endpackage

>>> rtl/vtre_mul.sv
// Unsigned 16x16 multiplier, one 4-bit digit of b per cycle.
module vtre_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vtre_pkg::RateW-1:0]  a_i,
  input  logic [vtre_pkg::RateW-1:0]  b_i,
  output logic [vtre_pkg::ProdW-1:0]  prod_o,
  output logic                        done_o
);
  import vtre_pkg::*;

  localparam logic [MulCntW-1:0] CntLast = MulCntW'(MulSteps - 1);
  localparam int unsigned HiW = RateW + DigitW;

  logic                busy_q, done_q;
  logic [MulCntW-1:0]  cnt_q;
  logic [RateW-1:0]    a_q, b_q;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [HiW-1:0]      part, hi_sum;

  always_comb begin
    part   = HiW'(a_q) * HiW'(b_q[DigitW-1:0]);
    hi_sum = HiW'(prod_q[ProdW-1:RateW]) + part;
    prod_d = {hi_sum, prod_q[RateW-1:DigitW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      prod_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_d;
      b_q    <= b_q >> DigitW;
    end
  end

  assign prod_o = prod_q;
  assign done_o = done_q;

endmodule

>>> rtl/vtre_sqrt.sv
// Floor square root, two radicand bits per cycle.
module vtre_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vtre_pkg::ProdW-1:0]    radicand_i,
  output logic [vtre_pkg::RateW-1:0]    root_o,
  output logic                          done_o
);
  import vtre_pkg::*;

  localparam logic [SqrtCntW-1:0] CntLast = SqrtCntW'(SqrtSteps - 1);
  localparam int unsigned RemW = RateW + 2;

  logic                 busy_q, done_q;
  logic [SqrtCntW-1:0]  cnt_q;
  logic [ProdW-1:0]     x_q;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [RateW-1:0]     root_q, root_d;
  logic [RemW+1:0]      rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, x_q[ProdW-1:ProdW-2]};
    trial  = (RemW+2)'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = RemW'(rem_sh - trial);
      root_d = {root_q[RateW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[RemW-1:0];
      root_d = {root_q[RateW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

>>> rtl/vtre_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module vtre_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vtre_pkg::ProdW-1:0]  dividend_i,
  input  logic [vtre_pkg::DivW-1:0]   divisor_i,
  output logic [vtre_pkg::ProdW-1:0]  quot_o,
  output logic                        done_o
);
  import vtre_pkg::*;

  localparam logic [DivCntW-1:0] CntLast = DivCntW'(DivSteps - 1);

  logic                busy_q, done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [ProdW-1:0]    quo_q;
  logic [DivW-1:0]     d_q, rem_q, rem_d;
  logic [DivW:0]       rem_sh;
  logic                qbit;

  always_comb begin
    rem_sh = {rem_q, quo_q[ProdW-1]};
    qbit   = (rem_sh >= {1'b0, d_q});
    rem_d  = qbit ? DivW'(rem_sh - {1'b0, d_q}) : rem_sh[DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      d_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[ProdW-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

>>> rtl/vertical_turn_rate_estimator.sv
// Observe item: six 16x4-digit serial products, a 16-step root, then a 32-step divider from accept to
// result word; a rejected item (root zero or below rate_floor) skips the divider.
// Trim item: the 32-step divider for the new trim; before any sample it goes straight to the output.
// One item at a time; the next is taken once the result sits in the output register.
// A stalled result word adds its stall cycles before the next item is taken.
// Reset (async, active low): state and trim cleared, rate_floor 500, stale_limit 100.
module vertical_turn_rate_estimator #(
  parameter int unsigned TRIM_SAMPLES = vtre_pkg::TrimSamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [vtre_pkg::RateW-1:0]    roll_rate_i,
  input  logic [vtre_pkg::RateW-1:0]    pitch_rate_i,
  input  logic [vtre_pkg::RateW-1:0]    yaw_rate_i,
  input  logic [vtre_pkg::RateW-1:0]    right_force_i,
  input  logic [vtre_pkg::RateW-1:0]    up_force_i,
  input  logic [vtre_pkg::RateW-1:0]    aft_force_i,
  input  logic [vtre_pkg::TimeW-1:0]    time_ms_i,
  input  logic [vtre_pkg::RateW-1:0]    reference_rate_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [vtre_pkg::RateW-1:0]    turn_rate_o,
  output logic [vtre_pkg::RateW-1:0]    trim_value_o,
  output logic                          rate_valid_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vtre_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vtre_pkg::RateW-1:0]    cfg_data_i
);
  import vtre_pkg::*;

  localparam logic [ProdW-1:0] Half     = ProdW'(TRIM_SAMPLES / 2);
  localparam logic [DivW-1:0]  TrimDiv  = DivW'(TRIM_SAMPLES);
  localparam logic [TermW-1:0] TermLast = TermYawUp;
  localparam logic [RateW-1:0] SatPos   = 16'h7fff;
  localparam logic [RateW-1:0] SatNeg   = 16'h8000;

  function automatic logic [RateW-1:0] abs16(input logic [RateW-1:0] x);
    abs16 = x[RateW-1] ? (~x + 1'b1) : x;
  endfunction

  // quotient magnitude with sign, saturated to int16
  function automatic logic [RateW-1:0] sat_q(input logic s, input logic [ProdW-1:0] q);
    if (s) begin
      sat_q = (q > ProdW'(32768)) ? SatNeg : RateW'(~q[RateW-1:0] + 1'b1);
    end else begin
      sat_q = (q > ProdW'(32767)) ? SatPos : q[RateW-1:0];
    end
  endfunction

  state_e state_q, state_d;

  // captured item
  logic               mode_q;
  logic [RateW-1:0]   roll_q, pitch_q, yaw_q, right_q, up_q, aft_q, ref_q;
  logic [TimeW-1:0]   time_q;

  // block state and config
  logic [RateW-1:0]   meas_q, trim_q, floor_q, stale_q;
  logic [TimeW-1:0]   last_q;
  logic               seen_q;
  logic [AccW-1:0]    acc_q;

  // per-item work registers
  logic [TermW-1:0]   term_q, term_sel;
  logic [ProdW-1:0]   sq_q;
  logic [AlongW-1:0]  along_q;
  logic [RateW-1:0]   mag_q;
  logic               acc_flag_q;

  logic               out_valid_q, out_acc_q, out_rv_q;
  logic [RateW-1:0]   out_rate_q, out_trim_q;

  logic               accept, out_load;
  logic               mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [ProdW-1:0]   mul_prod, div_quot, dividend;
  logic [RateW-1:0]   root;
  logic [DivW-1:0]    divisor;
  term_ops_t          ops_sel, ops_cur;
  logic               term_neg;
  logic [AlongW-1:0]  p_ext;
  logic [17:0]        err;
  logic [AccW:0]      sum;
  logic [AccW-1:0]    acc_abs, acc_sat;
  logic [AlongW-1:0]  along_abs;
  logic [RateW:0]     diff;
  logic [RateW-1:0]   rate_out;
  logic [TimeW-1:0]   age;
  logic               valid_out;

  function automatic term_ops_t term_ops(input logic [TermW-1:0] t,
                                         input logic [RateW-1:0] rl,
                                         input logic [RateW-1:0] pt,
                                         input logic [RateW-1:0] yw,
                                         input logic [RateW-1:0] rt,
                                         input logic [RateW-1:0] upf,
                                         input logic [RateW-1:0] af);
    term_ops_t o;
    o = '{a: rt, b: rt, neg: 1'b0};
    case (t)
      TermRightSq: o = '{a: rt,  b: rt,  neg: 1'b0};
      TermUpSq:    o = '{a: upf, b: upf, neg: 1'b0};
      TermAftSq:   o = '{a: af,  b: af,  neg: 1'b0};
      TermRollAft: o = '{a: rl,  b: af,  neg: 1'b0};
      TermPitchRt: o = '{a: pt,  b: rt,  neg: 1'b1};
      TermYawUp:   o = '{a: yw,  b: upf, neg: 1'b0};
      default:     o = '{a: rt,  b: rt,  neg: 1'b0};
    endcase
    return o;
  endfunction

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // FSM
  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    term_sel   = term_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i)     state_d = S_MUL_GO;
          else if (seen_q) state_d = S_TRIM;
          else             state_d = S_OUT;
        end
      end
      S_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          if (term_q == TermLast) begin
            state_d = S_SQRT_GO;
          end else begin
            // chain straight into the next product
            mul_start = 1'b1;
            term_sel  = term_q + 1'b1;
          end
        end
      end
      S_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          if ((root != '0) && (root >= floor_q)) state_d = S_DIV_GO;
          else                                   state_d = S_OUT;
        end
      end
      S_TRIM: begin
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // datapath
  always_comb begin
    ops_sel  = term_ops(term_sel, roll_q, pitch_q, yaw_q, right_q, up_q, aft_q);
    ops_cur  = term_ops(term_q, roll_q, pitch_q, yaw_q, right_q, up_q, aft_q);
    term_neg = ops_cur.a[RateW-1] ^ ops_cur.b[RateW-1] ^ ops_cur.neg;
    p_ext    = AlongW'(mul_prod);

    err = {{2{meas_q[RateW-1]}}, meas_q} - {{2{ref_q[RateW-1]}}, ref_q}
          - {{2{trim_q[RateW-1]}}, trim_q};
    sum = {acc_q[AccW-1], acc_q} + {{(AccW-17){err[17]}}, err};
    if (sum[AccW] != sum[AccW-1]) acc_sat = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                                      : {1'b0, {(AccW-1){1'b1}}};
    else                          acc_sat = sum[AccW-1:0];

    acc_abs   = acc_q[AccW-1] ? (~acc_q + 1'b1) : acc_q;
    along_abs = along_q[AlongW-1] ? (~along_q + 1'b1) : along_q;
    if (mode_q) begin
      dividend = acc_abs + Half;
      divisor  = TrimDiv;
    end else begin
      dividend = along_abs[ProdW-1:0];
      divisor  = mag_q;
    end

    diff = {meas_q[RateW-1], meas_q} - {trim_q[RateW-1], trim_q};
    if (diff[RateW] != diff[RateW-1]) rate_out = diff[RateW] ? SatNeg : SatPos;
    else                              rate_out = diff[RateW-1:0];
    age       = time_q - last_q;
    valid_out = seen_q && (age < TimeW'(stale_q));
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      roll_q  <= roll_rate_i;
      pitch_q <= pitch_rate_i;
      yaw_q   <= yaw_rate_i;
      right_q <= right_force_i;
      up_q    <= up_force_i;
      aft_q   <= aft_force_i;
      time_q  <= time_ms_i;
      ref_q   <= reference_rate_i;
      sq_q    <= '0;
      along_q <= '0;
    end else if ((state_q == S_MUL_WAIT) && mul_done) begin
      if (term_q <= TermAftSq) sq_q <= sq_q + mul_prod;
      else                     along_q <= term_neg ? (along_q - p_ext) : (along_q + p_ext);
    end
    if ((state_q == S_SQRT_WAIT) && sqrt_done) mag_q <= root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q     <= '0;
      acc_flag_q <= 1'b0;
      meas_q     <= '0;
      last_q     <= '0;
      seen_q     <= 1'b0;
      acc_q      <= '0;
      trim_q     <= '0;
    end else begin
      if (accept) begin
        term_q     <= '0;
        acc_flag_q <= 1'b0;
      end
      if ((state_q == S_MUL_WAIT) && mul_done) term_q <= term_q + 1'b1;
      if (state_q == S_TRIM) acc_q <= acc_sat;
      if ((state_q == S_DIV_WAIT) && div_done) begin
        if (mode_q) begin
          trim_q <= sat_q(acc_q[AccW-1], div_quot);
        end else begin
          meas_q     <= sat_q(along_q[AlongW-1], div_quot);
          last_q     <= time_q;
          seen_q     <= 1'b1;
          acc_flag_q <= 1'b1;
        end
      end
    end
  end

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= RateFloorRst;
      stale_q <= StaleLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRateFloor:  floor_q <= cfg_data_i;
        CfgStaleLimit: stale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_acc_q  <= acc_flag_q;
      out_rate_q <= rate_out;
      out_trim_q <= trim_q;
      out_rv_q   <= valid_out;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = out_acc_q;
  assign turn_rate_o  = out_rate_q;
  assign trim_value_o = out_trim_q;
  assign rate_valid_o = out_rv_q;

  vtre_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (abs16(ops_sel.a)),
    .b_i     (abs16(ops_sel.b)),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  vtre_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  vtre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // an accepted word blocks further input until its result is queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

  // once a sample has been stored it stays seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> seen_q)
    else $error("sample_seen dropped");

  // trim accumulator only moves after a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (acc_q == '0) && (trim_q == '0))
    else $error("trim moved before any sample");

  // an accepted flag on the output implies a stored sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> seen_q)
    else $error("accepted without stored sample");

endmodule
